FILE: sv/fixed_block_pool_allocator_assert.svh
// Assertion macros for the fixed block pool allocator.
// Relies on aclk and aresetn being visible where the macros are used.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FBPA_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/fbpa_pkg.sv
// Shared types and constants for the fixed block pool allocator.
// No dependencies.
package fbpa_pkg;

    localparam int OFF_W     = 12;
    localparam int REQ_W     = 16;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 9;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_FREE  = 2'd3;

    typedef struct packed {
        logic             action;
        logic [REQ_W-1:0] request_bytes;
        logic [OFF_W-1:0] block_offset;
    } fbpa_in_t;

    typedef struct packed {
        logic [OFF_W-1:0]     granted_offset;
        logic [STAT_W-1:0]    status;
        logic [CNT_OUT_W-1:0] blocks_in_use;
    } fbpa_out_t;

    typedef enum logic [1:0] {
        CS_INIT,
        CS_IDLE,
        CS_CALC,
        CS_COMMIT
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic init_step;
        logic load;
        logic calc;
        logic commit;
    } fbpa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic init_last;
        logic out_busy;
    } fbpa_stat_t;

endpackage

FILE: sv/fixed_block_pool_allocator.sv
// Fixed block pool allocator, top level: controller plus datapath.
// An accepted beat moves through the calc and commit states; its result beat is loaded, and m_valid set, at commit.
// A new beat is accepted only when the previous one commits, after its registered link-store read in calc.
// Reset: synchronous, active low; then an init sweep writes every link-store entry with
// s_ready low. Depends on fbpa_pkg, fbpa_ctrl, fbpa_dp and fixed_block_pool_allocator_assert.svh.
`include "fixed_block_pool_allocator_assert.svh"

module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int BLOCK_BYTES = 16,   // 1 .. 4096
    parameter int NUM_BLOCKS  = 256   // 2 .. 65536
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  fbpa_in_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output fbpa_out_t m_payload
);

    // Flow per beat:
    //   accept edge   - beat latched into the datapath input register
    //   calc cycle    - link store read at the free head, size/empty/range checks,
    //                   offset-to-index by reciprocal multiply, head-to-offset multiply
    //   commit cycle  - alignment check, head/count update, free pushes its link,
    //                   result beat loaded; the next beat may be accepted on this edge
    // Commit waits while the result register still holds an untaken beat.

    fbpa_cmd_t  cmd;
    fbpa_stat_t stat;

    fbpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fbpa_dp #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .NUM_BLOCKS  (NUM_BLOCKS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // no beat taken while the link store is being initialized
    `FBPA_ASSERT_IMPLIES(a_no_accept_in_init, cmd.init_step, !s_ready, "beat accepted during init")
    // an accepted beat always spends a calc cycle before the next accept
    `FBPA_ASSERT_NEXT(a_calc_after_accept, s_valid && s_ready, cmd.calc && !s_ready, "calc skipped")
    // failed requests never carry an offset
    `FBPA_ASSERT_IMPLIES(a_fail_zero_offset, m_valid && (m_payload.status != STAT_OK),
        m_payload.granted_offset == '0, "offset on failed request")

endmodule

FILE: sv/fbpa_ctrl.sv
// Sequencer for the pool allocator: link-store init sweep, then calc/commit per beat.
// Depends on fbpa_pkg.
module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  fbpa_stat_t stat,
    output fbpa_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            CS_INIT: begin
                cmd.init_step = 1'b1;
                if (stat.init_last) begin
                    state_next = CS_IDLE;
                end
            end
            CS_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = CS_CALC;
                end
            end
            CS_CALC: begin
                cmd.calc   = 1'b1;
                state_next = CS_COMMIT;
            end
            CS_COMMIT: begin
                // result register must be free before committing
                if (!stat.out_busy) begin
                    cmd.commit = 1'b1;
                    s_ready    = 1'b1;
                    if (s_valid) begin
                        cmd.load   = 1'b1;
                        state_next = CS_CALC;
                    end else begin
                        state_next = CS_IDLE;
                    end
                end
            end
            default: begin
                state_next = CS_INIT;
            end
        endcase
    end

endmodule

FILE: sv/fbpa_dp.sv
// Datapath for the pool allocator: link store, head and count registers, result register.
// Depends on fbpa_pkg.
module fbpa_dp
    import fbpa_pkg::*;
#(
    parameter int BLOCK_BYTES = 16,
    parameter int NUM_BLOCKS  = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  fbpa_in_t   s_payload,
    input  fbpa_cmd_t  cmd,
    output fbpa_stat_t stat,
    output logic       m_valid,
    input  logic       m_ready,
    output fbpa_out_t  m_payload
);

    localparam int LINK_W = $clog2(NUM_BLOCKS + 1);
    localparam int IDX_W  = $clog2(NUM_BLOCKS);
    localparam int BB_W   = $clog2(BLOCK_BYTES + 1);
    // offset / BLOCK_BYTES by reciprocal, exact for any OFF_W-bit offset
    localparam int RECIP_S = OFF_W + $clog2(BLOCK_BYTES);
    localparam int M_W     = RECIP_S + 1;
    localparam int QP_W    = OFF_W + M_W;
    localparam logic [M_W-1:0] RECIP_M =
        M_W'(((longint'(1) << RECIP_S) + longint'(BLOCK_BYTES) - 1) / BLOCK_BYTES);
    localparam int BK_W = OFF_W + BB_W;
    localparam int GP_W = LINK_W + BB_W;
    localparam logic [31:0] POOL_BYTES = 32'(longint'(NUM_BLOCKS) * BLOCK_BYTES);
    localparam logic [LINK_W-1:0] NB_LINK = LINK_W'(NUM_BLOCKS);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

    logic [LINK_W-1:0] link_mem [NUM_BLOCKS];

    fbpa_in_t          in_reg;
    logic [LINK_W-1:0] head_reg;
    logic [LINK_W-1:0] head_next;
    logic [LINK_W-1:0] used_reg;
    logic [LINK_W-1:0] used_next;
    logic [IDX_W-1:0]  init_cnt_reg;
    logic [LINK_W-1:0] rd_data_reg;
    logic [OFF_W-1:0]  idx_reg;
    logic [OFF_W-1:0]  gran_reg;
    logic              too_large_reg;
    logic              empty_reg;
    logic              in_pool_reg;
    logic              out_valid_reg;
    fbpa_out_t         out_reg;
    fbpa_out_t         out_next;

    logic [QP_W-1:0]   quot_prod;
    logic [BK_W-1:0]   back_prod;
    logic [GP_W-1:0]   gran_prod;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [LINK_W-1:0] wr_data;
    logic              aligned;
    logic              free_ok;

    assign quot_prod = QP_W'(in_reg.block_offset) * QP_W'(RECIP_M);
    assign gran_prod = GP_W'(head_reg) * GP_W'(BLOCK_BYTES);
    assign back_prod = BK_W'(idx_reg) * BK_W'(BLOCK_BYTES);
    assign aligned   = (back_prod == BK_W'(in_reg.block_offset));
    assign rd_addr   = (head_reg < NB_LINK) ? IDX_W'(head_reg) : '0;

    assign free_ok  = (in_reg.action == ACT_FREE) && in_pool_reg && aligned &&
                      (used_reg != '0);

    // commit: next head, count and result beat
    always_comb begin
        head_next = head_reg;
        used_next = used_reg;
        out_next  = '0;
        if (in_reg.action == ACT_ALLOC) begin
            if (too_large_reg) begin
                out_next.status = STAT_TOO_LARGE;
            end else if (empty_reg) begin
                out_next.status = STAT_EMPTY;
            end else begin
                out_next.status         = STAT_OK;
                out_next.granted_offset = gran_reg;
                head_next               = rd_data_reg;
                used_next               = used_reg + LINK_W'(1);
            end
        end else begin
            if (free_ok) begin
                out_next.status = STAT_OK;
                head_next       = LINK_W'(idx_reg);
                used_next       = used_reg - LINK_W'(1);
            end else begin
                out_next.status = STAT_BAD_FREE;
            end
        end
        out_next.blocks_in_use = CNT_OUT_W'(used_next);
    end

    // single write port: init sweep or a free's push
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = init_cnt_reg;
        wr_data = LINK_W'(init_cnt_reg) + LINK_W'(1);
        if (cmd.init_step) begin
            wr_en = 1'b1;
        end else if (cmd.commit && free_ok) begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(idx_reg);
            wr_data = head_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            link_mem[wr_addr] <= wr_data;
        end
        if (cmd.calc) begin
            rd_data_reg <= link_mem[rd_addr];
        end
    end

    // payload / pipeline registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= s_payload;
        end
        if (cmd.calc) begin
            idx_reg       <= OFF_W'(quot_prod >> RECIP_S);
            gran_reg      <= OFF_W'(gran_prod);
            too_large_reg <= (32'(in_reg.request_bytes) > 32'(BLOCK_BYTES));
            empty_reg     <= (head_reg >= NB_LINK) || (used_reg >= NB_LINK);
            in_pool_reg   <= (32'(in_reg.block_offset) < POOL_BYTES);
        end
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            used_reg      <= '0;
            init_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.init_step) begin
                init_cnt_reg <= init_cnt_reg + IDX_W'(1);
            end
            if (cmd.commit) begin
                head_reg      <= head_next;
                used_reg      <= used_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.init_last = (init_cnt_reg == LAST_IDX);
    assign stat.out_busy  = out_valid_reg && !m_ready;
    assign m_valid        = out_valid_reg;
    assign m_payload      = out_reg;

endmodule
